FILE: hw/rtl/rhcg_pkg.sv
// ----------------------------------------------------------------------------
// Rainbow hue colour generator: shared package
// Constants, types and the channel selection function used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package rhcg_pkg;

	// Hue arithmetic, in hundredths of a degree
	localparam int HUE_W = 16;
	localparam logic [15:0] HUE_FULL   = 16'd36000;
	localparam logic [16:0] HUE_FULL_X = 17'd36000;
	localparam logic [16:0] HUE_DOUBLE = 17'd72000;
	localparam logic [16:0] HUE_HALF   = 17'd18000;
	localparam logic [16:0] DEG_SCALE  = 17'd100;
	localparam logic [15:0] HUE_LIMIT  = 16'd37023;
	localparam logic [15:0] SECTOR_1   = 16'd6000;
	localparam logic [15:0] SECTOR_2   = 16'd12000;
	localparam logic [15:0] SECTOR_3   = 16'd18000;
	localparam logic [15:0] SECTOR_4   = 16'd24000;
	localparam logic [15:0] SECTOR_5   = 16'd30000;
	localparam logic [13:0] SECTOR_F   = 14'd6000;
	localparam logic [12:0] DIST_FULL  = 13'd6000;

	// Configuration
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam logic [2:0] CFG_SPEED  = 3'd0;
	localparam logic [2:0] CFG_SAT    = 3'd1;
	localparam logic [2:0] CFG_BRIGHT = 3'd2;
	localparam logic [2:0] CFG_OFF1   = 3'd3;
	localparam logic [2:0] CFG_OFF2   = 3'd4;
	localparam logic [2:0] CFG_SUPER  = 3'd5;
	localparam logic [2:0] CFG_PASTEL = 3'd6;
	localparam logic [9:0] SPEED_RESET = 10'd10;
	localparam logic [9:0] SUPER_STEP  = 10'd1000;
	localparam logic [6:0] PCT_MAX     = 7'd100;
	localparam logic [6:0] PASTEL_SAT  = 7'd50;
	localparam logic [6:0] PASTEL_VAL  = 7'd90;

	// Shared multiplier and constant division by 60e6/255 = 4e6/17
	localparam int MUL_A_W = 26;
	localparam int MUL_B_W = 23;
	localparam int PROD_W  = 49;
	localparam int QUOT_LSB = 40;
	localparam logic [19:0] W_FULL  = 20'd600000;
	localparam logic [22:0] RECIP17 = 23'd4672909;   // 17 * floor(2^40 / 4e6)
	localparam logic [22:0] DIV_D   = 23'd4000000;

	// Which channel value the sequencer works on
	localparam logic [2:0] VAL_MAX  = 3'd0;
	localparam logic [2:0] VAL_MIN  = 3'd1;
	localparam logic [2:0] VAL_X0   = 3'd2;
	localparam logic [2:0] VAL_LAST = 3'd5;

	localparam int N_COLORS = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SD,
		ST_VW,
		ST_RC,
		ST_QD,
		ST_STORE,
		ST_FINISH
	} seq_state_t;

	// Sectors of the hue circle, named by the strongest and the middle channel
	typedef enum logic [2:0] {
		SECT_R_G,
		SECT_G_R,
		SECT_G_B,
		SECT_B_G,
		SECT_B_R,
		SECT_R_B
	} hue_sector_t;

	typedef struct packed {
		logic [9:0] step;
		logic [6:0] sat;
		logic [6:0] val;
		logic [8:0] off_one;
		logic [8:0] off_two;
	} hsv_cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	function automatic rgb_t hsv_pick(hue_sector_t sec, logic [7:0] hi, logic [7:0] lo,
			logic [7:0] mid);
		rgb_t c;
		case (sec)
			SECT_R_G: begin
				c.red = hi;  c.green = mid; c.blue = lo;
			end
			SECT_G_R: begin
				c.red = mid; c.green = hi;  c.blue = lo;
			end
			SECT_G_B: begin
				c.red = lo;  c.green = hi;  c.blue = mid;
			end
			SECT_B_G: begin
				c.red = lo;  c.green = mid; c.blue = hi;
			end
			SECT_B_R: begin
				c.red = mid; c.green = lo;  c.blue = hi;
			end
			default: begin
				c.red = hi;  c.green = lo;  c.blue = mid;
			end
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rhcg_cfg.sv
// ----------------------------------------------------------------------------
// Rainbow hue colour generator: configuration registers
// Holds the seven settings and presents the effective step, saturation,
// brightness and offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module rhcg_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [rhcg_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [rhcg_pkg::CFG_DATA_W-1:0] wr_data,
	output rhcg_pkg::hsv_cfg_t                   cfg
);
	import rhcg_pkg::*;

	logic [9:0] speed_q;
	logic [6:0] sat_q;
	logic [6:0] bright_q;
	logic [8:0] off_one_q;
	logic [8:0] off_two_q;
	logic       super_q;
	logic       pastel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q   <= SPEED_RESET;
			sat_q     <= PCT_MAX;
			bright_q  <= PCT_MAX;
			off_one_q <= '0;
			off_two_q <= '0;
			super_q   <= 1'b0;
			pastel_q  <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SPEED:  speed_q   <= wr_data;
				CFG_SAT:    sat_q     <= wr_data[6:0];
				CFG_BRIGHT: bright_q  <= wr_data[6:0];
				CFG_OFF1:   off_one_q <= wr_data[8:0];
				CFG_OFF2:   off_two_q <= wr_data[8:0];
				CFG_SUPER:  super_q   <= wr_data[0];
				CFG_PASTEL: pastel_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.step    = super_q ? SUPER_STEP : speed_q;
		cfg.off_one = off_one_q;
		cfg.off_two = off_two_q;
		if (pastel_q) begin
			cfg.sat = PASTEL_SAT;
			cfg.val = PASTEL_VAL;
		end else begin
			cfg.sat = (sat_q > PCT_MAX) ? PCT_MAX : sat_q;
			cfg.val = (bright_q > PCT_MAX) ? PCT_MAX : bright_q;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rhcg_mul.sv
// ----------------------------------------------------------------------------
// Rainbow hue colour generator: shared multiplier
// One registered multiplier that the sequencer uses for each product of the level and quotient calculation.
// ----------------------------------------------------------------------------
`default_nettype none

module rhcg_mul (
	input  wire logic                          clk,
	input  wire logic [rhcg_pkg::MUL_A_W-1:0]  a,
	input  wire logic [rhcg_pkg::MUL_B_W-1:0]  b,
	output logic      [rhcg_pkg::PROD_W-1:0]   prod_q
);
	import rhcg_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rhcg_core.sv
// ----------------------------------------------------------------------------
// Rainbow hue colour generator: hue accumulator and conversion sequencer
// Updates the hue and works out six channel bytes, one after another, on the
// shared multiplier: the full and floor levels common to all colours, then
// the rising or falling level of each of the four colours.
// ----------------------------------------------------------------------------
`default_nettype none

module rhcg_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rhcg_pkg::hsv_cfg_t cfg,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               advance,
	output logic                    result_done,
	input  wire logic               result_take,
	output rhcg_pkg::rgb_t          colors [rhcg_pkg::N_COLORS]
);
	import rhcg_pkg::*;

	seq_state_t state_q, state_d;
	logic [2:0]  val_q;
	logic [15:0] hue_q;
	logic [15:0] hue_next;
	logic [15:0] h_q;
	logic [25:0] p_q;
	logic [7:0]  q0_q;
	logic [7:0]  max_q;
	logic [7:0]  min_q;
	logic [7:0]  x_q [N_COLORS];
	hue_sector_t sector_q [N_COLORS];

	logic              accept;
	logic [2:0]        val_off;
	logic [1:0]        color;
	logic              opp;
	logic [8:0]        off_sel;
	logic [16:0]       base;
	logic [15:0]       h_red;
	hue_sector_t       sector;
	logic [13:0]       f;
	logic [12:0]       ramp_gap;
	logic [12:0]       d;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic [8:0]        q_inc;
	logic [31:0]       p17;
	logic [7:0]        quot;

	rhcg_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign hue_next = (hue_q >= HUE_FULL) ? '0 : hue_q + 16'(cfg.step);

	// Colour being set up: first pair on offset one, second on offset two,
	// the odd one of each pair half a turn round.
	assign val_off = val_q - VAL_X0;
	assign color   = val_off[1:0];
	assign opp     = color[0];
	assign off_sel = color[1] ? cfg.off_two : cfg.off_one;

	always_comb begin
		base = {1'b0, hue_q} + 17'(off_sel) * DEG_SCALE + (opp ? HUE_HALF : '0);
		if (base >= HUE_DOUBLE)
			h_red = 16'(base - HUE_DOUBLE);
		else if (base >= HUE_FULL_X)
			h_red = 16'(base - HUE_FULL_X);
		else
			h_red = base[15:0];
	end

	always_comb begin
		if (h_q < SECTOR_1)
			sector = SECT_R_G;
		else if (h_q < SECTOR_2)
			sector = SECT_G_R;
		else if (h_q < SECTOR_3)
			sector = SECT_G_B;
		else if (h_q < SECTOR_4)
			sector = SECT_B_G;
		else if (h_q < SECTOR_5)
			sector = SECT_B_R;
		else
			sector = SECT_R_B;

		if (h_q >= SECTOR_4)
			f = 14'(h_q - SECTOR_4);
		else if (h_q >= SECTOR_2)
			f = 14'(h_q - SECTOR_2);
		else
			f = h_q[13:0];
		ramp_gap = (f >= SECTOR_F) ? 13'(f - SECTOR_F) : 13'(SECTOR_F - f);

		case (val_q)
			VAL_MAX: d = '0;
			VAL_MIN: d = DIST_FULL;
			default: d = ramp_gap;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_SETUP;
			ST_SETUP:  state_d = ST_SD;
			ST_SD:     state_d = ST_VW;
			ST_VW:     state_d = ST_RC;
			ST_RC:     state_d = ST_QD;
			ST_QD:     state_d = ST_STORE;
			ST_STORE:  state_d = (val_q == VAL_LAST) ? ST_FINISH : ST_SETUP;
			ST_FINISH: if (result_take) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Multiplier operands and handshake outputs. The level is
	// w = 600000 - s*d, then P = v*w, and the byte is floor(17*P / 4e6),
	// estimated by a reciprocal product and corrected by one compare.
	always_comb begin
		in_stall    = (state_q != ST_IDLE);
		result_done = (state_q == ST_FINISH);
		mul_a       = '0;
		mul_b       = '0;
		case (state_q)
			ST_SD: begin
				mul_a = MUL_A_W'(d);
				mul_b = MUL_B_W'(cfg.sat);
			end
			ST_VW: begin
				mul_a = MUL_A_W'(W_FULL - prod[19:0]);
				mul_b = MUL_B_W'(cfg.val);
			end
			ST_RC: begin
				mul_a = prod[MUL_A_W-1:0];
				mul_b = RECIP17;
			end
			ST_QD: begin
				mul_a = MUL_A_W'({1'b0, prod[QUOT_LSB+7:QUOT_LSB]} + 9'd1);
				mul_b = DIV_D;
			end
			default: ;
		endcase
	end

	assign q_inc = {1'b0, q0_q} + 9'd1;
	assign p17   = (32'(p_q) << 4) + 32'(p_q);
	assign quot  = (p17 >= prod[31:0]) ? q_inc[7:0] : q0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			val_q   <= '0;
			hue_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept)
				val_q <= VAL_MAX;
			else if (state_q == ST_STORE)
				val_q <= val_q + 3'd1;
			if (accept && advance)
				hue_q <= hue_next;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP)
			h_q <= h_red;
		if (state_q == ST_SD && val_q >= VAL_X0)
			sector_q[color] <= sector;
		if (state_q == ST_RC)
			p_q <= prod[MUL_A_W-1:0];
		if (state_q == ST_QD)
			q0_q <= prod[QUOT_LSB+7:QUOT_LSB];
		if (state_q == ST_STORE) begin
			case (val_q)
				VAL_MAX: max_q <= quot;
				VAL_MIN: min_q <= quot;
				default: x_q[color] <= quot;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < N_COLORS; i++)
			colors[i] = hsv_pick(sector_q[i], max_q, min_q, x_q[i]);
	end

	// The reciprocal estimate is never more than one below the true quotient.
	a_quot_corr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STORE) |-> (p17 < prod[31:0] + 32'(DIV_D)))
		else $error("quotient estimate off by more than one");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hue_q < HUE_LIMIT)
		else $error("hue accumulator out of range");

	a_h_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SD) |-> (h_q < HUE_FULL))
		else $error("colour hue not reduced below a full turn");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SETUP) && (val_q == VAL_MAX))
		else $error("sequence did not start on the full level");

endmodule

`default_nettype wire

FILE: hw/rtl/rainbow_hue_color_generator_unit.sv
// ----------------------------------------------------------------------------
// Rainbow hue colour generator
// Advances a hue accumulator on each accepted word that sets advance, and converts four related hues to RGB.
// ----------------------------------------------------------------------------
//
//   channel | handshake                  | payload
//   --------+----------------------------+------------------------------------
//   cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//   in      | in_valid / in_stall        | advance
//   out     | out_valid / out_stall      | {one,two}_{main,opp}_{red,green,blue}
//
// Each input word is worked through six channel levels, each taken through the
// shared multiplier (set-up, four products and a correcting compare); then the
// colours are handed to the output register and the sequencer returns to idle,
// in which the next word is accepted.
// Reset clears the hue to zero and loads the register defaults.
// A finished word waits in the sequencer while the output register is full
// and stalled; the input stays stalled until it has moved on.
// ----------------------------------------------------------------------------
`default_nettype none

module rainbow_hue_color_generator_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rhcg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rhcg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            advance,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [7:0]                           one_main_red,
	output logic [7:0]                           one_main_green,
	output logic [7:0]                           one_main_blue,
	output logic [7:0]                           one_opp_red,
	output logic [7:0]                           one_opp_green,
	output logic [7:0]                           one_opp_blue,
	output logic [7:0]                           two_main_red,
	output logic [7:0]                           two_main_green,
	output logic [7:0]                           two_main_blue,
	output logic [7:0]                           two_opp_red,
	output logic [7:0]                           two_opp_green,
	output logic [7:0]                           two_opp_blue
);
	import rhcg_pkg::*;

	hsv_cfg_t cfg;
	rgb_t     colors  [N_COLORS];
	rgb_t     color_q [N_COLORS];
	logic     out_valid_q;
	logic     result_done;
	logic     result_take;

	assign cfg_ready = 1'b1;

	rhcg_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	rhcg_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.advance     (advance),
		.result_done (result_done),
		.result_take (result_take),
		.colors      (colors)
	);

	// The output register takes a new word when it is empty or being emptied.
	assign result_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (result_done && result_take)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (result_done && result_take)
			color_q <= colors;
	end

	assign out_valid      = out_valid_q;
	assign one_main_red   = color_q[0].red;
	assign one_main_green = color_q[0].green;
	assign one_main_blue  = color_q[0].blue;
	assign one_opp_red    = color_q[1].red;
	assign one_opp_green  = color_q[1].green;
	assign one_opp_blue   = color_q[1].blue;
	assign two_main_red   = color_q[2].red;
	assign two_main_green = color_q[2].green;
	assign two_main_blue  = color_q[2].blue;
	assign two_opp_red    = color_q[3].red;
	assign two_opp_green  = color_q[3].green;
	assign two_opp_blue   = color_q[3].blue;

endmodule

`default_nettype wire
